// File: hdl/ipv6ehw_pkg.sv
// ----------------------------------------------------------------------------
// ipv6ehw_pkg
// Shared types, codes and decode functions for the IPv6 extension header
// walker.
// ----------------------------------------------------------------------------
package ipv6ehw_pkg;

  // next-header codes
  localparam logic [7:0] NH_HOP      = 8'd0;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_NONE     = 8'd59;
  localparam logic [7:0] NH_DEST     = 8'd60;

  // option type codes
  localparam logic [7:0] OPT_PAD1    = 8'h00;
  localparam logic [7:0] OPT_PADN    = 8'h01;
  localparam logic [7:0] OPT_TYPE_C9 = 8'hC9;
  localparam logic [7:0] OPT_TYPE_8C = 8'h8C;
  localparam logic [7:0] OPT_TYPE_8A = 8'h8A;
  localparam logic [7:0] OPT_TYPE_4D = 8'h4D;
  localparam logic [7:0] OPT_TYPE_6D = 8'h6D;
  localparam logic [7:0] OPT_TYPE_63 = 8'h63;

  // pending option action, taken from the top two bits of an unknown type
  localparam logic [1:0] PV_NONE       = 2'd0;
  localparam logic [1:0] PV_DROP       = 2'd1;
  localparam logic [1:0] PV_ICMP       = 2'd2;
  localparam logic [1:0] PV_ICMP_UCAST = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_DELIVER = 2'd0,
    VERDICT_DROP    = 2'd1,
    VERDICT_ICMP    = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } opt_phase_e;

  typedef enum logic [1:0] {
    ACT_DELIVER = 2'd0,
    ACT_DROP    = 2'd1,
    ACT_NEW_HDR = 2'd2
  } hdr_act_e;

  // one input transaction
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_byte;
    logic [7:0] initial_next_header;
    logic       dst_multicast;
    logic       last_byte;
  } pkt_in_t;

  // one result transaction
  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  upper_protocol;
    logic [15:0] payload_offset;
    logic [15:0] problem_offset;
  } result_t;

  // what a next-header value asks for
  function automatic hdr_act_e nh_action(input logic [7:0] nh, input logic seen);
    hdr_act_e act;
    unique case (nh) inside
      NH_HOP:               act = seen ? ACT_DROP : ACT_NEW_HDR;
      NH_NONE, NH_FRAGMENT: act = ACT_DROP;
      NH_DEST, NH_ROUTING:  act = ACT_NEW_HDR;
      default:              act = ACT_DELIVER;
    endcase
    return act;
  endfunction

  // option types skipped by length
  function automatic logic known_type(input logic [7:0] t);
    logic k;
    unique case (t) inside
      OPT_PADN, OPT_TYPE_C9, OPT_TYPE_8C, OPT_TYPE_8A,
      OPT_TYPE_4D, OPT_TYPE_6D, OPT_TYPE_63: k = 1'b1;
      default:                               k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// File: hdl/ipv6_ext_header_walker.sv
// The deciding byte sits in the input register, its verdict in the result register.
// Throughput: one byte per cycle through the input register and the result
// register; while a verdict waits to be taken the input stalls, whether or not
// the next byte decides a verdict.
// Reset: asynchronous, active low; the walker idles until a first byte arrives
// and both pipeline registers come up empty.
// ----------------------------------------------------------------------------
// ipv6_ext_header_walker
// Walks the Hop-by-Hop, Destination and Routing headers after an IPv6 header
// and gives one deliver, drop or parameter-problem verdict per packet.
// ----------------------------------------------------------------------------
module ipv6_ext_header_walker
  import ipv6ehw_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        first_byte_i,
  input  logic [7:0]  initial_next_header_i,
  input  logic        dst_multicast_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [7:0]  upper_protocol_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] problem_offset_o
);

  pkt_in_t pkt_in;
  pkt_in_t pkt_q;
  logic    pkt_valid;
  logic    advance;
  logic    go;
  logic    res_valid;
  result_t res;
  result_t res_q;

  assign pkt_in.packet_byte         = packet_byte_i;
  assign pkt_in.first_byte          = first_byte_i;
  assign pkt_in.initial_next_header = initial_next_header_i;
  assign pkt_in.dst_multicast       = dst_multicast_i;
  assign pkt_in.last_byte           = last_byte_i;

  // input stage
  ipv6ehw_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pkt_i      (pkt_in),
    .advance_i  (advance),
    .valid_o    (pkt_valid),
    .pkt_o      (pkt_q)
  );

  assign go = pkt_valid && advance;

  // walker state and per-byte logic
  ipv6ehw_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .pkt_i       (pkt_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result stage
  ipv6ehw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign verdict_o        = res_q.verdict;
  assign upper_protocol_o = res_q.upper_protocol;
  assign payload_offset_o = res_q.payload_offset;
  assign problem_offset_o = res_q.problem_offset;

endmodule

// File: hdl/ipv6ehw_in_reg.sv
// ----------------------------------------------------------------------------
// ipv6ehw_in_reg
// Input register: captures one byte transaction and holds it until the
// walker core can advance.
// ----------------------------------------------------------------------------
module ipv6ehw_in_reg
  import ipv6ehw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  pkt_in_t pkt_i,
  input  logic    advance_i,
  output logic    valid_o,
  output pkt_in_t pkt_o
);

  logic    valid_q;
  pkt_in_t pkt_q;

  // register takes a new transaction when empty or draining this cycle
  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      pkt_q <= pkt_i;
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

endmodule

// File: hdl/ipv6ehw_core.sv
// ----------------------------------------------------------------------------
// ipv6ehw_core
// Walker state and per-byte update: header chain, option TLV parsing and
// verdict generation, one byte per cycle while go_i is set.
// ----------------------------------------------------------------------------
module ipv6ehw_core
  import ipv6ehw_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    go_i,
  input  pkt_in_t pkt_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [7:0]              cur_nh_q, cur_nh_d;
  logic                    seen_q, seen_d;
  logic                    is_opt_q, is_opt_d;
  logic [11:0]             pos_q, pos_d;
  logic [11:0]             size_q, size_d;
  opt_phase_e              phase_q, phase_d;
  logic [7:0]              left_q, left_d;
  logic [1:0]              pend_q, pend_d;
  logic [OFFSET_WIDTH-1:0] soff_q, soff_d;
  logic [OFFSET_WIDTH-1:0] hstart_q, hstart_d;
  logic                    given_q, given_d;
  logic                    mcast_q, mcast_d;

  logic                    produce;
  logic                    proceed;
  logic                    hdr_done;
  logic [12:0]             pos_nx;
  logic [7:0]              left_m1;
  logic [OFFSET_WIDTH-1:0] next_off;
  logic [OFFSET_WIDTH-1:0] poff_w;
  logic [OFFSET_WIDTH-1:0] prob_w;
  logic [OFFSET_WIDTH+15:0] poff_ext;
  logic [OFFSET_WIDTH+15:0] prob_ext;
  verdict_e                verdict;
  logic [7:0]              proto;
  hdr_act_e                act0;
  hdr_act_e                act1;

  // per-byte state update
  always_comb begin
    cur_nh_d = cur_nh_q;
    seen_d   = seen_q;
    is_opt_d = is_opt_q;
    pos_d    = pos_q;
    size_d   = size_q;
    phase_d  = phase_q;
    left_d   = left_q;
    pend_d   = pend_q;
    soff_d   = soff_q;
    hstart_d = hstart_q;
    given_d  = given_q;
    mcast_d  = mcast_q;
    produce  = 1'b0;
    proceed  = 1'b0;
    hdr_done = 1'b0;
    verdict  = VERDICT_DELIVER;
    proto    = 8'd0;
    poff_w   = '0;
    prob_w   = '0;
    pos_nx   = 13'd0;
    left_m1  = 8'd0;
    next_off = '0;
    act0     = nh_action(pkt_i.initial_next_header, 1'b0);
    act1     = ACT_DELIVER;

    if (go_i) begin
      proceed = 1'b1;
      // start of a new packet
      if (pkt_i.first_byte) begin
        mcast_d = pkt_i.dst_multicast;
        seen_d  = 1'b0;
        given_d = 1'b0;
        soff_d  = '0;
        case (act0)
          ACT_DROP: begin
            produce = 1'b1;
            verdict = VERDICT_DROP;
            given_d = 1'b1;
            proceed = 1'b0;
          end
          ACT_DELIVER: begin
            produce = 1'b1;
            proto   = pkt_i.initial_next_header;
            given_d = 1'b1;
            proceed = 1'b0;
          end
          default: begin
            seen_d   = 1'b1;
            is_opt_d = (pkt_i.initial_next_header != NH_ROUTING);
            pos_d    = 12'd0;
            size_d   = 12'd0;
            phase_d  = PH_TYPE;
            left_d   = 8'd0;
            pend_d   = PV_NONE;
            hstart_d = '0;
          end
        endcase
      end else if (given_q) begin
        proceed = 1'b0;
      end

      if (proceed) begin
        // header byte fields
        if (pos_d == 12'd0) begin
          cur_nh_d = pkt_i.packet_byte;
        end else if (pos_d == 12'd1) begin
          size_d = {1'b0, pkt_i.packet_byte, 3'b000} + 12'd8;
        end else if (is_opt_d && (pend_d == PV_NONE)) begin
          // option tlv parsing
          case (phase_d)
            PH_TYPE: begin
              if (pkt_i.packet_byte != OPT_PAD1) begin
                phase_d = PH_LEN;
                if (!known_type(pkt_i.packet_byte) && (pkt_i.packet_byte[7:6] != PV_NONE)) begin
                  pend_d = pkt_i.packet_byte[7:6];
                end
              end
            end
            PH_LEN: begin
              left_d  = pkt_i.packet_byte;
              phase_d = (pkt_i.packet_byte != 8'd0) ? PH_DATA : PH_TYPE;
            end
            default: begin
              left_m1 = left_d - 8'd1;
              left_d  = left_m1;
              if (left_m1 == 8'd0) begin
                phase_d = PH_TYPE;
              end
            end
          endcase
        end

        pos_nx   = {1'b0, pos_d} + 13'd1;
        pos_d    = pos_nx[11:0];
        hdr_done = (pos_nx >= 13'd2) && (pos_nx == {1'b0, size_d});

        // header complete: option verdict, then chain decision
        if (hdr_done) begin
          if (is_opt_d && (pend_d == PV_DROP)) begin
            produce = 1'b1;
            verdict = VERDICT_DROP;
          end else if (is_opt_d && ((pend_d == PV_ICMP) ||
                                    ((pend_d == PV_ICMP_UCAST) && !mcast_d))) begin
            produce = 1'b1;
            verdict = VERDICT_ICMP;
            prob_w  = hstart_d;
          end else if (is_opt_d && (pend_d == PV_ICMP_UCAST)) begin
            produce = 1'b1;
            verdict = VERDICT_DROP;
          end else if (is_opt_d && (phase_d != PH_TYPE)) begin
            produce = 1'b1;
            verdict = VERDICT_DROP;
          end else begin
            next_off = soff_d + 1'b1;
            act1     = nh_action(cur_nh_d, seen_d);
            case (act1)
              ACT_DROP: begin
                produce = 1'b1;
                verdict = VERDICT_DROP;
              end
              ACT_DELIVER: begin
                produce = 1'b1;
                proto   = cur_nh_d;
                poff_w  = next_off;
              end
              default: begin
                seen_d   = 1'b1;
                is_opt_d = (cur_nh_d != NH_ROUTING);
                pos_d    = 12'd0;
                size_d   = 12'd0;
                phase_d  = PH_TYPE;
                left_d   = 8'd0;
                pend_d   = PV_NONE;
                hstart_d = next_off;
              end
            endcase
          end
        end

        // truncated packet
        if (!produce && pkt_i.last_byte) begin
          produce = 1'b1;
          verdict = VERDICT_DROP;
        end
        if (produce) begin
          given_d = 1'b1;
        end
        soff_d = soff_d + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_nh_q <= 8'd0;
      seen_q   <= 1'b0;
      is_opt_q <= 1'b0;
      pos_q    <= 12'd0;
      size_q   <= 12'd0;
      phase_q  <= PH_TYPE;
      left_q   <= 8'd0;
      pend_q   <= PV_NONE;
      soff_q   <= '0;
      hstart_q <= '0;
      given_q  <= 1'b1;
      mcast_q  <= 1'b0;
    end else begin
      cur_nh_q <= cur_nh_d;
      seen_q   <= seen_d;
      is_opt_q <= is_opt_d;
      pos_q    <= pos_d;
      size_q   <= size_d;
      phase_q  <= phase_d;
      left_q   <= left_d;
      pend_q   <= pend_d;
      soff_q   <= soff_d;
      hstart_q <= hstart_d;
      given_q  <= given_d;
      mcast_q  <= mcast_d;
    end
  end

  // fit offsets to the 16-bit result fields
  assign poff_ext = {16'd0, poff_w};
  assign prob_ext = {16'd0, prob_w};

  assign res_valid_o         = produce;
  assign res_o.verdict        = verdict;
  assign res_o.upper_protocol = proto;
  assign res_o.payload_offset = poff_ext[15:0];
  assign res_o.problem_offset = prob_ext[15:0];

endmodule

// File: hdl/ipv6ehw_out_reg.sv
// ----------------------------------------------------------------------------
// ipv6ehw_out_reg
// Result register: holds one verdict transaction until the receiver takes
// it, and tells the upstream stages when they may advance.
// ----------------------------------------------------------------------------
module ipv6ehw_out_reg
  import ipv6ehw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    go_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // register is free when empty or being taken this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= go_i && res_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && go_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
